FILE: sv/rgb_to_hsv_converter_top_assert.svh
// Assertion macros for the RGB to HSV converter RTL.
`ifndef RGB_TO_HSV_CONVERTER_TOP_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTH

// Checks that a condition holds at every clock edge outside reset.
`define RTH_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle whenever the antecedent does.
`define RTH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define RTH_ASSERT(lbl, cond, msg)
`define RTH_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

FILE: sv/rth_pkg.sv
// Types, widths and the division step function of the RGB to HSV converter.
package rth_pkg;

    // Component width and full-scale value, 255 standing for 1.0.
    localparam int CompW   = 8;
    localparam int HsvFull = 255;

    // Numerator over six times the chroma; at most 6*255 plus one component.
    localparam int HueNW   = 11;

    // Divider operand widths: hue is (510n + 6d) / 12d, sat is (510d + mx) / 2mx.
    localparam int HueNumW = 20;
    localparam int HueDivW = 12;
    localparam int SatNumW = 17;
    localparam int SatDivW = 9;

    // Both quotients stay below 256, so eight restoring steps suffice.
    localparam int QuoW     = 8;
    localparam int DivSteps = QuoW;

    // Register stages ahead of the divider: sort, then numerator build.
    localparam int FrontStg = 2;

    // Which component holds the maximum.
    typedef enum logic [2:0] {
        SecRed   = 3'b001,
        SecGreen = 3'b010,
        SecBlue  = 3'b100
    } sector_t;

    // After the first stage: sorted extremes and the original components.
    typedef struct packed {
        logic [CompW-1:0] mx;
        logic [CompW-1:0] mn;
        logic [CompW-1:0] red;
        logic [CompW-1:0] green;
        logic [CompW-1:0] blue;
        sector_t          sector;
    } front1_t;

    // After the second stage: chroma and the hue numerator over 6d.
    typedef struct packed {
        logic [CompW-1:0] mx;
        logic [CompW-1:0] d;
        logic [HueNW-1:0] n;
    } front2_t;

    // One slot of the shared divider pipeline, both divisions side by side.
    typedef struct packed {
        logic [CompW-1:0]   val;
        logic [HueNumW-1:0] hue_rem;
        logic [HueDivW-1:0] hue_div;
        logic [QuoW-1:0]    hue_quo;
        logic [SatNumW-1:0] sat_rem;
        logic [SatDivW-1:0] sat_div;
        logic [QuoW-1:0]    sat_quo;
        logic               hue_zero;
        logic               sat_zero;
    } div_t;

    // One restoring division step that settles quotient bit k of both quotients.
    function automatic div_t div_step(input div_t s, input int unsigned k);
        div_t               r;
        logic [HueNumW-1:0] h_trial;
        logic [SatNumW-1:0] s_trial;
        r       = s;
        h_trial = HueNumW'(s.hue_div) << k;
        s_trial = SatNumW'(s.sat_div) << k;
        if (s.hue_rem >= h_trial)
        begin
            r.hue_rem = s.hue_rem - h_trial;
            r.hue_quo = s.hue_quo | (QuoW'(1) << k);
        end
        if (s.sat_rem >= s_trial)
        begin
            r.sat_rem = s.sat_rem - s_trial;
            r.sat_quo = s.sat_quo | (QuoW'(1) << k);
        end
        return r;
    endfunction

endpackage

FILE: sv/rth_rgb_if.sv
// Pixel input channel: valid, ready and one RGB pixel.
interface rth_rgb_if;
    import rth_pkg::*;

    logic             valid;
    logic             ready;
    logic [CompW-1:0] red_in;
    logic [CompW-1:0] green_in;
    logic [CompW-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

FILE: sv/rth_hsv_if.sv
// Result output channel: valid, ready and one HSV pixel.
interface rth_hsv_if;
    import rth_pkg::*;

    logic             valid;
    logic             ready;
    logic [CompW-1:0] hue_out;
    logic [CompW-1:0] sat_out;
    logic [CompW-1:0] val_out;

    modport source (output valid, output hue_out, output sat_out, output val_out,
                    input ready);
    modport sink   (input valid, input hue_out, input sat_out, input val_out,
                    output ready);
endinterface

FILE: sv/rgb_to_hsv_converter_top.sv
// Pipelined RGB to HSV pixel converter with a restoring divider per quotient bit.
//
// Channel   Modport  Payload                        Beat
// pix_in    sink     red_in, green_in, blue_in      valid && ready
// hsv_out   source   hue_out, sat_out, val_out      valid && ready
//
// One pixel enters per clock while the output is not stalled.
// Two front stages sort the components and build the hue numerator, one stage
// forms both dividends and divisors, and eight stages each settle one quotient bit.
// Every stage has its own valid bit and loads when empty or when the stage after
// it moves, so bubbles close up and a stalled output loses and repeats nothing.
// Reset clears the valid bits only; the payload registers are not reset.
module rgb_to_hsv_converter_top (
    input  logic         clk,
    input  logic         rst_n,
    rth_rgb_if.sink      pix_in,
    rth_hsv_if.source    hsv_out
);
    import rth_pkg::*;

    `include "rgb_to_hsv_converter_top_assert.svh"

    localparam int NumStg = FrontStg + DivSteps + 1;

    logic [NumStg-1:0] vld_reg;
    logic [NumStg-1:0] load;

    front1_t f1_reg;
    front1_t f1_next;
    front2_t f2_reg;
    front2_t f2_next;
    div_t    div_reg  [DivSteps+1];
    div_t    div_next [DivSteps+1];

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb
    begin
        load[NumStg-1] = !vld_reg[NumStg-1] || hsv_out.ready;
        for (int i = NumStg - 2; i >= 0; i--)
        begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign pix_in.ready = load[0];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                vld_reg[0] <= pix_in.valid;
            end
            for (int i = 1; i < NumStg; i++)
            begin
                if (load[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // First stage: find the maximum and minimum; red wins ties, then green.
    always_comb
    begin
        f1_next.red   = pix_in.red_in;
        f1_next.green = pix_in.green_in;
        f1_next.blue  = pix_in.blue_in;
        if (pix_in.red_in >= pix_in.green_in && pix_in.red_in >= pix_in.blue_in)
        begin
            f1_next.sector = SecRed;
            f1_next.mx     = pix_in.red_in;
        end
        else if (pix_in.green_in >= pix_in.blue_in)
        begin
            f1_next.sector = SecGreen;
            f1_next.mx     = pix_in.green_in;
        end
        else
        begin
            f1_next.sector = SecBlue;
            f1_next.mx     = pix_in.blue_in;
        end
        f1_next.mn = pix_in.red_in;
        if (pix_in.green_in < f1_next.mn)
        begin
            f1_next.mn = pix_in.green_in;
        end
        if (pix_in.blue_in < f1_next.mn)
        begin
            f1_next.mn = pix_in.blue_in;
        end
    end

    // Second stage: chroma and the hue numerator with its sector offset.
    // The sum is never negative, so modulo arithmetic at this width is exact.
    always_comb
    begin
        logic [HueNW-1:0] d_w;
        d_w        = HueNW'(f1_reg.mx - f1_reg.mn);
        f2_next.mx = f1_reg.mx;
        f2_next.d  = f1_reg.mx - f1_reg.mn;
        case (f1_reg.sector)
            SecRed:
            begin
                f2_next.n = HueNW'(f1_reg.green) - HueNW'(f1_reg.blue);
                if (f1_reg.green < f1_reg.blue)
                begin
                    f2_next.n = f2_next.n + (d_w << 2) + (d_w << 1);
                end
            end
            SecGreen:
            begin
                f2_next.n = (d_w << 1) + HueNW'(f1_reg.blue) - HueNW'(f1_reg.red);
            end
            SecBlue:
            begin
                f2_next.n = (d_w << 2) + HueNW'(f1_reg.red) - HueNW'(f1_reg.green);
            end
            default:
            begin
                f2_next.n = '0;
            end
        endcase
    end

    // Third stage: dividends carry the half divisor so that truncation rounds.
    // The divider stages after it each settle one quotient bit, most significant first.
    always_comb
    begin
        div_next[0].val      = f2_reg.mx;
        div_next[0].hue_rem  = HueNumW'(f2_reg.n) * HueNumW'(2 * HsvFull)
                             + HueNumW'(f2_reg.d) * HueNumW'(6);
        div_next[0].hue_div  = HueDivW'(f2_reg.d) * HueDivW'(12);
        div_next[0].hue_quo  = '0;
        div_next[0].sat_rem  = SatNumW'(f2_reg.d) * SatNumW'(2 * HsvFull)
                             + SatNumW'(f2_reg.mx);
        div_next[0].sat_div  = SatDivW'(f2_reg.mx) << 1;
        div_next[0].sat_quo  = '0;
        div_next[0].hue_zero = (f2_reg.d == '0);
        div_next[0].sat_zero = (f2_reg.mx == '0);
        for (int j = 0; j < DivSteps; j++)
        begin
            div_next[j+1] = div_step(div_reg[j], DivSteps - 1 - j);
        end
    end

    // Payload registers, loaded with their stage.
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            f1_reg <= f1_next;
        end
        if (load[1])
        begin
            f2_reg <= f2_next;
        end
        for (int j = 0; j <= DivSteps; j++)
        begin
            if (load[FrontStg+j])
            begin
                div_reg[j] <= div_next[j];
            end
        end
    end

    // Output beat; the quotients never exceed full scale, so no clamp is needed.
    assign hsv_out.valid   = vld_reg[NumStg-1];
    assign hsv_out.hue_out = div_reg[DivSteps].hue_zero ? '0 : div_reg[DivSteps].hue_quo;
    assign hsv_out.sat_out = div_reg[DivSteps].sat_zero ? '0 : div_reg[DivSteps].sat_quo;
    assign hsv_out.val_out = div_reg[DivSteps].val;

    // A ready output frees the whole pipeline back to the input.
    `RTH_ASSERT_IMPL(a_ready_chain, hsv_out.ready, pix_in.ready, "input stalled while output ready")

    // Finished hue division leaves a remainder below its divisor.
    `RTH_ASSERT_IMPL(a_hue_rem, vld_reg[NumStg-1] && !div_reg[DivSteps].hue_zero, div_reg[DivSteps].hue_rem < HueNumW'(div_reg[DivSteps].hue_div), "hue remainder not reduced")

    // Finished saturation division leaves a remainder below its divisor.
    `RTH_ASSERT_IMPL(a_sat_rem, vld_reg[NumStg-1] && !div_reg[DivSteps].sat_zero, div_reg[DivSteps].sat_rem < SatNumW'(div_reg[DivSteps].sat_div), "saturation remainder not reduced")

    // Zero saturation means a grey or black pixel, whose hue is zero.
    `RTH_ASSERT_IMPL(a_grey_hue, hsv_out.valid && hsv_out.sat_out == '0, hsv_out.hue_out == '0, "grey pixel with nonzero hue")

    // Black output pixels carry no saturation.
    `RTH_ASSERT(a_black_sat, !(hsv_out.valid && hsv_out.val_out == '0 && hsv_out.sat_out != '0), "black pixel with nonzero saturation")

endmodule

FILE: verif/tb_rgb_to_hsv_converter_top.sv
// Testbench for the RGB to HSV converter: random and directed pixels checked against a predictor.
module tb_rgb_to_hsv_converter_top;
    import rth_pkg::*;

    // Run limits: the limit is far above the slowest correct run.
    localparam int CycleLimit = 200000;
    localparam int TailCycles = 40;
    localparam int PhaseItems = 270;
    localparam int IdlePct    = 61;
    localparam int BothPct    = 27;

    // Handshake pressure applied during one phase of the run.
    typedef enum logic [1:0] {
        FlowFree,
        FlowSendGaps,
        FlowRecvStalls,
        FlowBoth
    } flow_t;

    typedef struct packed {
        logic [CompW-1:0] red;
        logic [CompW-1:0] green;
        logic [CompW-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [CompW-1:0] hue;
        logic [CompW-1:0] sat;
        logic [CompW-1:0] val;
    } hsv_t;

    logic clk;
    logic rst_n = 1'b0;

    rth_rgb_if pix_if ();
    rth_hsv_if hsv_if ();

    pixel_t      pending_pixels[$];
    hsv_t        expected_hsv[$];
    pixel_t      pixel_on_bus;
    hsv_t        oldest_hsv;
    hsv_t        seen_hsv;
    flow_t       flow = FlowFree;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    rgb_to_hsv_converter_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_if.sink),
        .hsv_out (hsv_if.source)
    );

    // Clock with a period of 20.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Exact integer hexcone conversion of one pixel, halves rounded up.
    function automatic hsv_t convert_pixel(input pixel_t p);
        hsv_t        h;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned top;
        int unsigned bottom;
        int unsigned chroma;
        int unsigned numer;
        int unsigned hue;
        r      = p.red;
        g      = p.green;
        b      = p.blue;
        top    = r;
        bottom = r;
        if (g > top) top = g;
        if (b > top) top = b;
        if (g < bottom) bottom = g;
        if (b < bottom) bottom = b;
        chroma = top - bottom;
        h.val  = CompW'(top);
        h.sat  = '0;
        h.hue  = '0;
        if (top != 0)
            h.sat = CompW'((2 * HsvFull * chroma + top) / (2 * top));
        if (chroma != 0)
        begin
            // Ties go to red first, then green.
            if (top == r)
                numer = (g < b) ? 6 * chroma - (b - g) : g - b;
            else if (top == g)
                numer = 2 * chroma + b - r;
            else
                numer = 4 * chroma + r - g;
            hue = (2 * HsvFull * numer + 6 * chroma) / (12 * chroma);
            if (hue > HsvFull)
                hue = HsvFull;
            h.hue = CompW'(hue);
        end
        return h;
    endfunction

    // One component drawn from the ends of the range.
    function automatic logic [CompW-1:0] extreme_level();
        case ($urandom_range(3))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Random pixel: mostly uniform, with near-grey, tied and extreme pixels mixed in.
    function automatic pixel_t random_pixel();
        pixel_t           p;
        int unsigned      kind;
        logic [CompW-1:0] level;
        kind    = $urandom_range(99);
        level   = CompW'($urandom);
        p.red   = CompW'($urandom);
        p.green = CompW'($urandom);
        p.blue  = CompW'($urandom);
        if (kind < 15)
        begin
            p.red   = level;
            p.green = level + CompW'($urandom_range(2));
            p.blue  = level - CompW'($urandom_range(2));
        end
        else if (kind < 30)
        begin
            case ($urandom_range(2))
                0:       p.green = p.red;
                1:       p.blue = p.green;
                default: p.blue = p.red;
            endcase
        end
        else if (kind < 42)
        begin
            p.red   = extreme_level();
            p.green = extreme_level();
            p.blue  = extreme_level();
        end
        return p;
    endfunction

    function automatic logic sender_pauses();
        if (flow == FlowSendGaps)
            return $urandom_range(99) < IdlePct;
        if (flow == FlowBoth)
            return $urandom_range(99) < BothPct;
        return 1'b0;
    endfunction

    function automatic logic receiver_takes();
        if (flow == FlowRecvStalls)
            return $urandom_range(99) >= IdlePct;
        if (flow == FlowBoth)
            return $urandom_range(99) >= BothPct;
        return 1'b1;
    endfunction

    task automatic add_pixel(input int r, input int g, input int b);
        pending_pixels.push_back({CompW'(r), CompW'(g), CompW'(b)});
    endtask

    // Waits at falling edges until every pixel has gone in and every result has come out.
    task automatic drain_pipeline();
        while (pending_pixels.size() != 0 || pix_if.valid || expected_hsv.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input flow_t f);
        flow = f;
        repeat (PhaseItems)
            pending_pixels.push_back(random_pixel());
        drain_pipeline();
    endtask

    // Pixel driver: holds a beat while stalled, otherwise offers the next queued pixel or idles.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pix_if.valid <= 1'b0;
        end
        else
        begin
            if (pix_if.valid && pix_if.ready)
                expected_hsv.push_back(convert_pixel(pixel_on_bus));
            if (!pix_if.valid || pix_if.ready)
            begin
                if (pending_pixels.size() != 0 && !sender_pauses())
                begin
                    pixel_on_bus = pending_pixels.pop_front();
                    pix_if.valid    <= 1'b1;
                    pix_if.red_in   <= pixel_on_bus.red;
                    pix_if.green_in <= pixel_on_bus.green;
                    pix_if.blue_in  <= pixel_on_bus.blue;
                end
                else
                begin
                    // Idle cycle: the payload carries noise.
                    pix_if.valid    <= 1'b0;
                    pix_if.red_in   <= CompW'($urandom);
                    pix_if.green_in <= CompW'($urandom);
                    pix_if.blue_in  <= CompW'($urandom);
                end
            end
        end
    end

    // Result monitor: every beat is compared with the oldest expected HSV pixel.
    always @(posedge clk)
    begin
        if (rst_n && hsv_if.valid && hsv_if.ready)
        begin
            seen_hsv = {hsv_if.hue_out, hsv_if.sat_out, hsv_if.val_out};
            if (expected_hsv.size() == 0)
            begin
                $error("unexpected result beat: hue %0d sat %0d val %0d",
                       seen_hsv.hue, seen_hsv.sat, seen_hsv.val);
                fail_count++;
            end
            else
            begin
                oldest_hsv = expected_hsv.pop_front();
                if (seen_hsv.hue !== oldest_hsv.hue)
                begin
                    $error("hue_out: expected %0d, actual %0d", oldest_hsv.hue, seen_hsv.hue);
                    fail_count++;
                end
                if (seen_hsv.sat !== oldest_hsv.sat)
                begin
                    $error("sat_out: expected %0d, actual %0d", oldest_hsv.sat, seen_hsv.sat);
                    fail_count++;
                end
                if (seen_hsv.val !== oldest_hsv.val)
                begin
                    $error("val_out: expected %0d, actual %0d", oldest_hsv.val, seen_hsv.val);
                    fail_count++;
                end
            end
        end
        hsv_if.ready <= receiver_takes();
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        pix_if.valid    = 1'b0;
        pix_if.red_in   = '0;
        pix_if.green_in = '0;
        pix_if.blue_in  = '0;
        hsv_if.ready    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Black, white and grey pixels.
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(128, 128, 128);
        add_pixel(1, 1, 1);
        // Primaries and secondaries; secondaries exercise ties for the maximum.
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 255, 0);
        add_pixel(0, 255, 255);
        add_pixel(255, 0, 255);
        add_pixel(200, 200, 10);
        add_pixel(10, 200, 200);
        add_pixel(200, 10, 200);
        // Hue just short of a full turn, which rounds up to full scale, and hue just past zero.
        add_pixel(255, 0, 1);
        add_pixel(255, 0, 2);
        add_pixel(255, 1, 0);
        // Smallest nonzero components and alternating bit patterns.
        add_pixel(1, 0, 0);
        add_pixel(0, 1, 0);
        add_pixel(0, 0, 1);
        add_pixel(170, 85, 255);
        add_pixel(85, 170, 0);
        add_pixel(255, 254, 253);

        // The sender holds off here until the directed results are all back.
        flow = FlowFree;
        drain_pipeline();

        run_phase(FlowFree);
        run_phase(FlowSendGaps);
        run_phase(FlowRecvStalls);
        run_phase(FlowBoth);

        repeat (TailCycles) @(posedge clk);
        if (fail_count == 0 && expected_hsv.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/rth_pkg.sv
sv/rth_rgb_if.sv
sv/rth_hsv_if.sv
sv/rgb_to_hsv_converter_top.sv
verif/tb_rgb_to_hsv_converter_top.sv
